/* design/qtrm_pkg.sv */
package qtrm_pkg;

    // Component width of the input quaternion (signed Q1.15)
    localparam int COMP_W = 16;
    // Product and sum widths
    localparam int PROD_W = 2 * COMP_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int NUM_W  = PROD_W + 2;
    // Divider widths: den = 2*s, rem = |n|*2^15 + s
    localparam int DEN_W  = SUM_W + 1;
    localparam int FRAC_W = 15;
    localparam int REM_W  = SUM_W + FRAC_W + 1;
    localparam int QUO_W  = 16;
    localparam int POS_W  = $clog2(QUO_W);
    localparam int OUT_W  = 16;
    localparam int LANES  = 9;

    localparam logic [OUT_W-1:0] ONE_Q14 = OUT_W'(16384);

    // One beat travelling down the divider chain, all nine entries in parallel
    typedef struct packed {
        logic                             valid;
        logic                             zero;
        logic [DEN_W-1:0]                 den;
        logic [LANES-1:0]                 neg;
        logic [LANES-1:0][REM_W-1:0]      rem;
        logic [LANES-1:0][QUO_W-1:0]      quo;
    } div_pipe_t;

endpackage

/* design/quaternion_to_rotation_matrix.sv */
// Quaternion to 3x3 rotation matrix.
// Slave stream: one quaternion per beat, tdata = {qz, qy, qx, qw}, each signed
// Q1.15, any nonzero length. Master stream: the nine matrix entries r00..r22
// in signed Q2.14 (row-major, r00 in the lowest bits), rounded half away from
// zero and clamped to +/-1.0; tuser carries zero_length, set when the input was
// all zero, in which case the identity matrix is returned.
// The pipeline has three front stages (products, sums, dividend), sixteen
// divider cells that each resolve one quotient bit for all nine entries, and
// the output register. Throughput is one beat per cycle; a new quaternion is
// taken every cycle while the output is free or being taken.
// When the receiver holds tready low with a result waiting, the whole pipeline
// freezes and s_axis_tready drops until the result is taken.
// Reset clears all valid bits; no results are pending after reset.
module quaternion_to_rotation_matrix
    import qtrm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [4*COMP_W-1:0]      s_axis_tdata,  // qw, qx, qy, qz
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [LANES*OUT_W-1:0]   m_axis_tdata,  // r00, r01, r02, r10 .. r22
    output logic                     m_axis_tuser   // zero_length
);

    logic                    en;
    div_pipe_t               pipe [QUO_W+1];
    logic                    out_valid_reg;
    logic [LANES*OUT_W-1:0]  out_data_reg, out_data_next;
    logic                    out_zero_reg;

    // Whole pipeline advances when the output slot is free or being drained
    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    qtrm_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_axis_tvalid),
        .in_data  (s_axis_tdata),
        .dout     (pipe[0])
    );

    // Divider chain, most significant quotient bit first
    for (genvar g = 0; g < QUO_W; g++)
    begin : g_cell
        qtrm_div_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .pos   (POS_W'(QUO_W - 1 - g)),
            .din   (pipe[g]),
            .dout  (pipe[g+1])
        );
    end

    // Clamp, apply sign, identity on zero length
    always_comb
    begin
        logic [QUO_W-1:0] qc;
        for (int l = 0; l < LANES; l++)
        begin
            qc = (pipe[QUO_W].quo[l] > QUO_W'(ONE_Q14)) ? QUO_W'(ONE_Q14)
                                                         : pipe[QUO_W].quo[l];
            if (pipe[QUO_W].zero)
                out_data_next[l*OUT_W +: OUT_W] = (l % 4 == 0) ? ONE_Q14 : '0;
            else if (pipe[QUO_W].neg[l])
                out_data_next[l*OUT_W +: OUT_W] = OUT_W'(-qc);
            else
                out_data_next[l*OUT_W +: OUT_W] = OUT_W'(qc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= pipe[QUO_W].valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
            out_zero_reg <= pipe[QUO_W].zero;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_zero_reg;

    // Zero-length input gives the identity: r00 is 1.0 and r01 is zero
    a_zero_identity: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |->
            m_axis_tdata[OUT_W-1:0] == ONE_Q14 && m_axis_tdata[2*OUT_W-1:OUT_W] == '0)
        else $error("zero-length result is not identity");

    // Entries r00 and r01 stay within +/-1.0
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            ($signed(m_axis_tdata[OUT_W-1:0]) <= $signed(ONE_Q14)) &&
            ($signed(m_axis_tdata[OUT_W-1:0]) >= -$signed(ONE_Q14)) &&
            ($signed(m_axis_tdata[2*OUT_W-1:OUT_W]) <= $signed(ONE_Q14)) &&
            ($signed(m_axis_tdata[2*OUT_W-1:OUT_W]) >= -$signed(ONE_Q14)))
        else $error("matrix entry out of range");

    // A stalled output freezes the chain
    a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(pipe[QUO_W].valid))
        else $error("divider chain moved during stall");

endmodule

/* design/qtrm_front.sv */
module qtrm_front
    import qtrm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [4*COMP_W-1:0]   in_data,
    output div_pipe_t             dout
);

    logic signed [COMP_W-1:0] qw, qx, qy, qz;

    logic                     v1_reg, v2_reg;
    logic signed [PROD_W-1:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [PROD_W-1:0] xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;
    logic [SUM_W-1:0]         s_reg;
    logic signed [NUM_W-1:0]  n_reg [LANES];
    div_pipe_t                dout_reg, dout_next;

    assign qw = $signed(in_data[COMP_W-1:0]);
    assign qx = $signed(in_data[2*COMP_W-1:COMP_W]);
    assign qy = $signed(in_data[3*COMP_W-1:2*COMP_W]);
    assign qz = $signed(in_data[4*COMP_W-1:3*COMP_W]);

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    // Stage 1: the ten products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ww_reg <= qw * qw;
            xx_reg <= qx * qx;
            yy_reg <= qy * qy;
            zz_reg <= qz * qz;
            xy_reg <= qx * qy;
            xz_reg <= qx * qz;
            yz_reg <= qy * qz;
            wx_reg <= qw * qx;
            wy_reg <= qw * qy;
            wz_reg <= qw * qz;
        end
    end

    // Stage 2: squared length and the nine numerators
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg    <= SUM_W'(NUM_W'(ww_reg) + NUM_W'(xx_reg) + NUM_W'(yy_reg)
                        + NUM_W'(zz_reg));
            n_reg[0] <= NUM_W'(ww_reg) + NUM_W'(xx_reg) - NUM_W'(yy_reg) - NUM_W'(zz_reg);
            n_reg[1] <= (NUM_W'(xy_reg) - NUM_W'(wz_reg)) <<< 1;
            n_reg[2] <= (NUM_W'(xz_reg) + NUM_W'(wy_reg)) <<< 1;
            n_reg[3] <= (NUM_W'(xy_reg) + NUM_W'(wz_reg)) <<< 1;
            n_reg[4] <= NUM_W'(ww_reg) - NUM_W'(xx_reg) + NUM_W'(yy_reg) - NUM_W'(zz_reg);
            n_reg[5] <= (NUM_W'(yz_reg) - NUM_W'(wx_reg)) <<< 1;
            n_reg[6] <= (NUM_W'(xz_reg) - NUM_W'(wy_reg)) <<< 1;
            n_reg[7] <= (NUM_W'(yz_reg) + NUM_W'(wx_reg)) <<< 1;
            n_reg[8] <= NUM_W'(ww_reg) - NUM_W'(xx_reg) - NUM_W'(yy_reg) + NUM_W'(zz_reg);
        end
    end

    // Stage 3: magnitude, sign and rounded dividend
    always_comb
    begin
        logic [NUM_W-1:0] mag;
        dout_next       = '0;
        dout_next.valid = v2_reg;
        dout_next.zero  = (s_reg == '0);
        dout_next.den   = {s_reg, 1'b0};
        for (int l = 0; l < LANES; l++)
        begin
            mag               = n_reg[l][NUM_W-1] ? NUM_W'(-n_reg[l]) : NUM_W'(n_reg[l]);
            dout_next.neg[l]  = n_reg[l][NUM_W-1];
            dout_next.rem[l]  = (REM_W'(mag) << FRAC_W) + REM_W'(s_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dout_reg <= '0;
        else if (en)
            dout_reg <= dout_next;
    end

    assign dout = dout_reg;

endmodule

/* design/qtrm_div_cell.sv */
module qtrm_div_cell
    import qtrm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic [POS_W-1:0] pos,
    input  div_pipe_t        din,
    output div_pipe_t        dout
);

    div_pipe_t dout_reg, dout_next;

    // One restoring step: try to take den << pos from each remainder
    always_comb
    begin
        logic [REM_W:0] trial;
        dout_next = din;
        for (int l = 0; l < LANES; l++)
        begin
            trial = {1'b0, din.rem[l]} - ((REM_W+1)'(din.den) << pos);
            if (!trial[REM_W])
            begin
                dout_next.rem[l]      = trial[REM_W-1:0];
                dout_next.quo[l][pos] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dout_reg <= '0;
        else if (en)
            dout_reg <= dout_next;
    end

    assign dout = dout_reg;

endmodule
